>>> src/v3n_pkg.sv
// Shared constants and pipeline payload types for the 3D vector normalizer.
package v3n_pkg;

    // Field widths
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = FRAC_BITS + 2;
    localparam int EPS_BITS   = 16;
    localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd66;

    // Internal widths
    localparam int MAG_BITS  = COORD_BITS;          // |coord| fits unsigned
    localparam int SUM_BITS  = 2 * MAG_BITS;        // 3 * 2^46 < 2^48
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int SREM_BITS = ROOT_BITS + 3;       // root remainder
    localparam int QUO_BITS  = FRAC_BITS + 1;       // quotient <= 2^FRAC_BITS
    localparam int DREM_BITS = ROOT_BITS + 1;       // divider remainder

    // Packed stream widths
    localparam int IN_DATA_BITS  = 3 * COORD_BITS;
    localparam int OUT_FLD_BITS  = 3 * OUT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FLD_BITS + 7) / 8) * 8;

    localparam logic [QUO_BITS-1:0] UNIT_ONE = QUO_BITS'(1) << FRAC_BITS;

    typedef logic [MAG_BITS-1:0] mag_t;

    // Payload through the square root stages
    typedef struct packed {
        logic [2:0]           sign;
        mag_t [2:0]           mag;
        logic                 tiny;
        logic [SUM_BITS-1:0]  radicand;
        logic [ROOT_BITS-1:0] root;
        logic [SREM_BITS-1:0] rem;
    } sqrt_stage_t;

    // Payload through the divider stages
    typedef struct packed {
        logic [2:0]                 sign;
        logic [2:0][DREM_BITS-1:0]  rem;
        logic [2:0][QUO_BITS-1:0]   quo;
        logic [ROOT_BITS-1:0]       len;
        logic                       zero;
    } div_stage_t;

endpackage

>>> src/vector3_normalize.sv
// Pipelined 3D vector normalizer: Q7.16 vector in, Q1.16 unit vector out.
//
// One vector is accepted every cycle unless the output is stalled. Stages:
// 3 for magnitude, squares and sum, 24 of a one-bit-per-stage square root,
// one for the zero test, 17 of a one-bit-per-stage restoring divider
// (three lanes in parallel) and the output register. The whole pipe moves
// on one advance signal, so s_axis_tready follows the output slot being
// free. A vector whose length is zero or below epsilon, or whose every
// component magnitude is below epsilon, gives a zero result with is_zero
// set. The user must write epsilon through cfg_we/cfg_wdata while no
// transaction is in flight; the block itself does not enforce this.
module vector3_normalize
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [v3n_pkg::EPS_BITS-1:0]        cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vec_x, vec_y, vec_z
    input  logic [v3n_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // unit_x, unit_y, unit_z, zero pad
    output logic [v3n_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // is_zero
    output logic                                m_axis_tuser
);

    localparam int NSQ  = v3n_pkg::ROOT_BITS;
    localparam int NDIV = v3n_pkg::QUO_BITS;
    localparam int CB   = v3n_pkg::COORD_BITS;
    localparam int OB   = v3n_pkg::OUT_BITS;

    logic                          adv;
    logic [v3n_pkg::EPS_BITS-1:0]  eps_reg;

    // Epsilon register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= v3n_pkg::EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_wdata;
    end

    // Whole pipe advances when the output slot is free or being taken
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage A: sign, magnitude, small test
    logic                     a_vld_reg;
    logic [2:0]               a_sign_reg;
    v3n_pkg::mag_t [2:0]      a_mag_reg;
    logic                     a_small_reg;
    logic [2:0]               a_sign_next;
    v3n_pkg::mag_t [2:0]      a_mag_next;
    logic                     a_small_next;

    always_comb
    begin
        logic [CB-1:0] c;
        a_small_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            c = s_axis_tdata[i*CB +: CB];
            a_sign_next[i] = c[CB-1];
            a_mag_next[i]  = c[CB-1] ? (~c + CB'(1)) : c;
            if (a_mag_next[i] >= v3n_pkg::MAG_BITS'(eps_reg))
                a_small_next = 1'b0;
        end
    end

    // Stage B: squares
    logic                                 b_vld_reg;
    logic [2:0]                           b_sign_reg;
    v3n_pkg::mag_t [2:0]                  b_mag_reg;
    logic                                 b_small_reg;
    logic [2:0][v3n_pkg::SUM_BITS-1:0]    b_sq_reg;

    // Stage C is the entry of the square root pipe
    logic                  sq_vld_reg [0:NSQ];
    v3n_pkg::sqrt_stage_t  sq_reg     [0:NSQ];
    v3n_pkg::sqrt_stage_t  sq_next    [1:NSQ];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg    <= s_axis_tvalid;
            b_vld_reg    <= a_vld_reg;
            sq_vld_reg[0] <= b_vld_reg;
        end
    end

    // Front payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sign_reg  <= a_sign_next;
            a_mag_reg   <= a_mag_next;
            a_small_reg <= a_small_next;
            b_sign_reg  <= a_sign_reg;
            b_mag_reg   <= a_mag_reg;
            b_small_reg <= a_small_reg;
            for (int i = 0; i < 3; i++)
                b_sq_reg[i] <= a_mag_reg[i] * a_mag_reg[i];
            sq_reg[0].sign     <= b_sign_reg;
            sq_reg[0].mag      <= b_mag_reg;
            sq_reg[0].tiny     <= b_small_reg;
            sq_reg[0].radicand <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            sq_reg[0].root     <= '0;
            sq_reg[0].rem      <= '0;
        end
    end

    // Square root: one result bit per stage
    genvar k;
    generate
        for (k = 0; k < NSQ; k++)
        begin : g_sqrt
            always_comb
            begin
                logic [v3n_pkg::SREM_BITS-1:0] r;
                logic [v3n_pkg::SREM_BITS-1:0] trial;
                sq_next[k+1] = sq_reg[k];
                r = {sq_reg[k].rem[v3n_pkg::SREM_BITS-3:0],
                     sq_reg[k].radicand[v3n_pkg::SUM_BITS-1 -: 2]};
                trial = {1'b0, sq_reg[k].root, 2'b01};
                sq_next[k+1].radicand = sq_reg[k].radicand << 2;
                if (r >= trial)
                begin
                    sq_next[k+1].rem  = r - trial;
                    sq_next[k+1].root = {sq_reg[k].root[NSQ-2:0], 1'b1};
                end
                else
                begin
                    sq_next[k+1].rem  = r;
                    sq_next[k+1].root = {sq_reg[k].root[NSQ-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_vld_reg[k+1] <= 1'b0;
                else if (adv)
                    sq_vld_reg[k+1] <= sq_vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    sq_reg[k+1] <= sq_next[k+1];
            end
        end
    endgenerate

    // Zero test, then divider pipe
    logic                 dv_vld_reg [0:NDIV];
    v3n_pkg::div_stage_t  dv_reg     [0:NDIV];
    v3n_pkg::div_stage_t  dv_next    [0:NDIV];

    always_comb
    begin
        dv_next[0].sign = sq_reg[NSQ].sign;
        dv_next[0].len  = sq_reg[NSQ].root;
        dv_next[0].zero = (sq_reg[NSQ].root == '0) || sq_reg[NSQ].tiny ||
                          (sq_reg[NSQ].root < v3n_pkg::ROOT_BITS'(eps_reg));
        for (int i = 0; i < 3; i++)
        begin
            dv_next[0].rem[i] = v3n_pkg::DREM_BITS'(sq_reg[NSQ].mag[i]);
            dv_next[0].quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (adv)
            dv_vld_reg[0] <= sq_vld_reg[NSQ];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= dv_next[0];
    end

    // Restoring divider: one quotient bit per stage, three lanes
    generate
        for (k = 0; k < NDIV; k++)
        begin : g_div
            always_comb
            begin
                logic [v3n_pkg::DREM_BITS-1:0] t;
                logic [v3n_pkg::DREM_BITS-1:0] d;
                dv_next[k+1] = dv_reg[k];
                d = v3n_pkg::DREM_BITS'(dv_reg[k].len);
                for (int i = 0; i < 3; i++)
                begin
                    if (k == 0)
                        t = dv_reg[k].rem[i];
                    else
                        t = dv_reg[k].rem[i] << 1;
                    if (t >= d)
                    begin
                        dv_next[k+1].rem[i] = t - d;
                        dv_next[k+1].quo[i] = {dv_reg[k].quo[i][NDIV-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_next[k+1].rem[i] = t;
                        dv_next[k+1].quo[i] = {dv_reg[k].quo[i][NDIV-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_vld_reg[k+1] <= 1'b0;
                else if (adv)
                    dv_vld_reg[k+1] <= dv_vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    dv_reg[k+1] <= dv_next[k+1];
            end
        end
    endgenerate

    // Output: saturate, apply sign, zero mask
    logic                              out_vld_reg;
    logic [v3n_pkg::OUT_DATA_BITS-1:0] out_data_reg;
    logic                              out_zero_reg;
    logic [v3n_pkg::OUT_DATA_BITS-1:0] out_data_next;

    always_comb
    begin
        logic [v3n_pkg::QUO_BITS-1:0] q;
        logic [OB-1:0]                u;
        out_data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = dv_reg[NDIV].quo[i];
            if (q > v3n_pkg::UNIT_ONE)
                q = v3n_pkg::UNIT_ONE;
            u = OB'(q);
            if (dv_reg[NDIV].sign[i])
                u = ~u + OB'(1);
            if (dv_reg[NDIV].zero)
                u = '0;
            out_data_next[i*OB +: OB] = u;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dv_vld_reg[NDIV];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_zero_reg <= dv_reg[NDIV].zero;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

endmodule

>>> src/v3n_checker.sv
// Port-level checker for the vector normalizer, bound to the top level.
module v3n_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [v3n_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    input logic                                m_axis_tuser
);

    localparam int OB = v3n_pkg::OUT_BITS;

    logic signed [OB-1:0] ux;
    logic signed [OB-1:0] uy;
    logic signed [OB-1:0] uz;
    logic signed [OB-1:0] lim_p;
    logic signed [OB-1:0] lim_n;

    assign ux    = m_axis_tdata[0 +: OB];
    assign uy    = m_axis_tdata[OB +: OB];
    assign uz    = m_axis_tdata[2*OB +: OB];
    assign lim_p = OB'(v3n_pkg::UNIT_ONE);
    assign lim_n = -lim_p;

    // A zero result carries all-zero components
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero flag with nonzero components");

    // Components stay within the unit range
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (ux <= lim_p && ux >= lim_n && uy <= lim_p &&
                           uy >= lim_n && uz <= lim_p && uz >= lim_n))
        else $error("component outside unit range");

    // Input stalls only while the output is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind vector3_normalize v3n_checker u_v3n_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb_vector3_normalize.sv
// Self-checking testbench for the 3D vector normalizer stream block.
module tb_vector3_normalize;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [v3n_pkg::OUT_BITS-1:0] ux;
        logic signed [v3n_pkg::OUT_BITS-1:0] uy;
        logic signed [v3n_pkg::OUT_BITS-1:0] uz;
        logic                                zflag;
    } unit_vec_t;

    typedef struct {
        logic [v3n_pkg::COORD_BITS-1:0] x;
        logic [v3n_pkg::COORD_BITS-1:0] y;
        logic [v3n_pkg::COORD_BITS-1:0] z;
        bit                             has_exp;
        unit_vec_t                      exp;
    } vec_row_t;

    localparam int LATENCY = 46;
    localparam int OBT = v3n_pkg::OUT_BITS;
    localparam int CBT = v3n_pkg::COORD_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [v3n_pkg::EPS_BITS-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [v3n_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [v3n_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tuser;

    logic [v3n_pkg::EPS_BITS-1:0] eps_model;
    unit_vec_t expected_units[$];
    int errors = 0;

    vector3_normalize i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bitwise integer square root, rounded down
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [OBT-1:0] scaled_comp(longint c, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? -c : c;
        q = (mag << v3n_pkg::FRAC_BITS) / len;
        if (q > (64'd1 << v3n_pkg::FRAC_BITS)) q = 64'd1 << v3n_pkg::FRAC_BITS;
        if (c < 0) q = -q;
        return q[OBT-1:0];
    endfunction

    // Expected unit vector for one input vector under the current epsilon
    function automatic unit_vec_t normalize_vec(logic [CBT-1:0] x,
                                                logic [CBT-1:0] y,
                                                logic [CBT-1:0] z);
        longint c[3];
        longint unsigned a;
        longint unsigned sum;
        longint unsigned len;
        bit tiny;
        unit_vec_t r;
        c[0] = longint'(signed'(x));
        c[1] = longint'(signed'(y));
        c[2] = longint'(signed'(z));
        sum = 0;
        tiny = 1;
        for (int i = 0; i < 3; i++)
        begin
            a = (c[i] < 0) ? -c[i] : c[i];
            sum += a * a;
            if (a >= eps_model) tiny = 0;
        end
        len = root_floor(sum);
        if (len == 0 || len < eps_model || tiny)
        begin
            r.ux = '0; r.uy = '0; r.uz = '0; r.zflag = 1'b1;
        end
        else
        begin
            r.ux = scaled_comp(c[0], len);
            r.uy = scaled_comp(c[1], len);
            r.uz = scaled_comp(c[2], len);
            r.zflag = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Send one vector transaction, optionally with a fixed expectation
    task automatic send_vec(logic [CBT-1:0] x, logic [CBT-1:0] y,
                            logic [CBT-1:0] z, bit has_exp, unit_vec_t exp);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tdata <= {z, y, x};
        s_axis_tvalid <= 1'b1;
        if (has_exp)
            expected_units.push_back(exp);
        else
            expected_units.push_back(normalize_vec(x, y, z));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_then_config(logic [v3n_pkg::EPS_BITS-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (expected_units.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        eps_model = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CBT-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CBT'(CBT'($urandom_range(0, 200)) *
                           (($urandom_range(0, 1)) ? -1 : 1));
            1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            2: return CBT'(CBT'($urandom_range(0, 65536 * 2)) *
                           (($urandom_range(0, 1)) ? -1 : 1));
            default: return CBT'($urandom());
        endcase
    endfunction

    // Output side: random backpressure and field checks
    always @(negedge clk)
    begin
        int g;
        if (rst_n)
        begin
            g = gap_len();
            m_axis_tready <= (g == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        unit_vec_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_units.size() == 0)
                report_mismatch("unexpected output transaction", 1, 0);
            else
            begin
                e = expected_units.pop_front();
                if (m_axis_tdata[OBT-1:0] !== e.ux)
                    report_mismatch("unit_x", signed'(m_axis_tdata[OBT-1:0]), e.ux);
                if (m_axis_tdata[2*OBT-1:OBT] !== e.uy)
                    report_mismatch("unit_y", signed'(m_axis_tdata[2*OBT-1:OBT]), e.uy);
                if (m_axis_tdata[3*OBT-1:2*OBT] !== e.uz)
                    report_mismatch("unit_z",
                                    signed'(m_axis_tdata[3*OBT-1:2*OBT]), e.uz);
                if (m_axis_tuser !== e.zflag)
                    report_mismatch("is_zero", m_axis_tuser, e.zflag);
            end
        end
    end

    // Directed table; fixed expectations only for obvious rows
    vec_row_t directed[$];
    unit_vec_t zero_res = '{ux: 0, uy: 0, uz: 0, zflag: 1};
    unit_vec_t px = '{ux: 65536, uy: 0, uz: 0, zflag: 0};
    unit_vec_t nz = '{ux: 0, uy: 0, uz: -65536, zflag: 0};

    initial
    begin
        logic [v3n_pkg::EPS_BITS-1:0] eps_set[5];
        directed.push_back('{0, 0, 0, 1, zero_res});
        directed.push_back('{24'h7fffff, 0, 0, 1, px});
        directed.push_back('{0, 0, 24'h800000, 1, nz});
        directed.push_back('{24'h800000, 24'h800000, 24'h800000, 0, zero_res});
        directed.push_back('{24'h7fffff, 24'h7fffff, 24'h7fffff, 0, zero_res});
        directed.push_back('{24'h7fffff, 24'h800000, 24'h7fffff, 0, zero_res});
        directed.push_back('{65, 65, 65, 1, zero_res});          // all parts small
        directed.push_back('{66, 0, 0, 0, zero_res});
        directed.push_back('{40, 40, 40, 0, zero_res});
        directed.push_back('{-24'sd65, 0, 0, 1, zero_res});
        directed.push_back('{65536, 65536, 65536, 0, zero_res});
        directed.push_back('{1, 24'hffffff, 1, 1, zero_res});
        directed.push_back('{3, 4, 0, 0, zero_res});
        directed.push_back('{24'haaaaaa, 24'h555555, 24'h123456, 0, zero_res});
        directed.push_back('{24'h555555, 24'haaaaaa, 24'hedcba9, 0, zero_res});

        eps_model = v3n_pkg::EPS_RESET;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_vec(directed[i].x, directed[i].y, directed[i].z,
                     directed[i].has_exp, directed[i].exp);

        // Zero epsilon: tiny vectors must still normalize, zero stays zero
        idle_then_config(16'd0);
        send_vec(0, 0, 0, 1, zero_res);
        send_vec(1, 0, 0, 1, px);
        send_vec(1, 1, 1, 0, zero_res);
        idle_then_config(16'hffff);
        send_vec(24'h00ffff, 0, 0, 0, zero_res);
        send_vec(24'h010000, 0, 0, 0, zero_res);

        eps_set = '{16'd0, 16'hffff, 16'd66, 16'd1, 16'h8000};
        for (int p = 0; p < 6; p++)
        begin
            idle_then_config(p < 5 ? eps_set[p] : 16'($urandom()));
            for (int k = 0; k < 150; k++)
                send_vec(rand_coord(), rand_coord(), rand_coord(), 0, zero_res);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_units.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0)
            $display("vector3_normalize verification clean");
        else
            $display("vector3_normalize verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("vector3_normalize verification failed");
        $finish;
    end
endmodule
